[hw/rtl/prks_pkg.sv]
// Shared types, constants and the arctangent table for the planar robot kinematic simulator.
package prks_pkg;

    localparam int MULA_W = 42;
    localparam int MULB_W = 24;
    localparam int MULC_W = 5;
    localparam int PROD_W = 66;
    localparam int CRD_W  = 34;
    localparam int ATAN_N = 24;
    localparam int ATAN_IW = 5;

    localparam logic [CRD_W-1:0] CORDIC_INV_GAIN = CRD_W'(652032874);

    localparam logic [1:0] REG_SAMPLE_TIME = 2'd0;
    localparam logic [1:0] REG_LAG_GAIN    = 2'd1;
    localparam logic [1:0] REG_DELAY_TICKS = 2'd2;

    localparam logic [3:0] OP_LAG_X  = 4'd0;
    localparam logic [3:0] OP_LAG_Y  = 4'd1;
    localparam logic [3:0] OP_LAG_T  = 4'd2;
    localparam logic [3:0] OP_RX_A   = 4'd3;
    localparam logic [3:0] OP_RX_B   = 4'd4;
    localparam logic [3:0] OP_RY_A   = 4'd5;
    localparam logic [3:0] OP_RY_B   = 4'd6;
    localparam logic [3:0] OP_DIST_X = 4'd7;
    localparam logic [3:0] OP_DIST_Y = 4'd8;
    localparam logic [3:0] OP_HEAD   = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_WRITE,
        ST_READ,
        ST_OUT
    } prks_state_t;

    typedef struct packed {
        logic                     start;
        logic signed [MULA_W-1:0] a;
        logic [MULB_W-1:0]        b;
        logic                     b_signed;
        logic signed [PROD_W-1:0] acc_init;
    } prks_mul_req_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] turn_rate;
    } prks_hist_t;

    function automatic logic [29:0] prks_atan(input logic [ATAN_IW-1:0] i);
        logic [29:0] r;
        case (i)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10679838;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/prks_smul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle, with preloaded accumulator.
module prks_smul (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  prks_pkg::prks_mul_req_t          req,
    output logic                             done,
    output logic signed [prks_pkg::PROD_W-1:0] prod
);
    import prks_pkg::*;

    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] a_reg, a_next;
    logic [MULB_W-1:0]        b_reg, b_next;
    logic [MULC_W-1:0]        cnt_reg, cnt_next;
    logic                     sgn_reg, sgn_next;
    logic                     done_reg, done_next;
    logic signed [PROD_W-1:0] addend;

    always_comb begin
        addend    = (sgn_reg && cnt_reg == MULC_W'(1)) ? -a_reg : a_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        sgn_next  = sgn_reg;
        done_next = 1'b0;
        if (req.start) begin
            acc_next = req.acc_init;
            a_next   = {{(PROD_W-MULA_W){req.a[MULA_W-1]}}, req.a};
            b_next   = req.b;
            sgn_next = req.b_signed;
            cnt_next = MULC_W'(MULB_W);
        end else if (cnt_reg != '0) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + addend;
            end
            a_next    = a_reg <<< 1;
            b_next    = b_reg >> 1;
            cnt_next  = cnt_reg - MULC_W'(1);
            done_next = (cnt_reg == MULC_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        sgn_reg <= sgn_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[hw/rtl/prks_cordic.sv]
// Iterative CORDIC rotation, one step per cycle, giving cos and sin of a binary angle in Q4.30.
module prks_cordic #(
    parameter int STEPS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [31:0]                       angle,
    output logic                              done,
    output logic signed [prks_pkg::CRD_W-1:0] cos_out,
    output logic signed [prks_pkg::CRD_W-1:0] sin_out
);
    import prks_pkg::*;

    logic signed [CRD_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [CRD_W-1:0] xs, ys, at;
    logic [ATAN_IW-1:0]      i_reg, i_next;
    logic                    busy_reg, busy_next, done_reg, done_next, flip_reg, flip_next;
    logic                    flip;
    logic [31:0]             h;

    always_comb begin
        flip      = angle[31] ^ angle[30];
        h         = flip ? angle + 32'h8000_0000 : angle;
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        at        = {{(CRD_W-30){1'b0}}, prks_atan(i_reg)};
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        flip_next = flip_reg;
        if (start) begin
            x_next    = CORDIC_INV_GAIN;
            y_next    = '0;
            z_next    = {{(CRD_W-32){h[31]}}, h};
            i_next    = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
            flip_next = flip;
        end else if (busy_reg) begin
            if (!z_reg[CRD_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            if (i_reg == ATAN_IW'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                i_next = i_reg + ATAN_IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        i_reg    <= i_next;
        flip_reg <= flip_next;
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

[hw/rtl/prks_hist.sv]
// State history memory: one write port, one registered read port.
module prks_hist #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  prks_pkg::prks_hist_t wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output prks_pkg::prks_hist_t rd_data
);
    import prks_pkg::*;

    prks_hist_t mem [DEPTH];
    prks_hist_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/planar_robot_kinematic_sim.sv]
// Top level of the planar robot kinematic simulator: sequencer, state and output register.
// Usage:
//   One s_ transaction is one simulation tick carrying commanded vx, vy and turn rate.
//   Each tick produces exactly one m_ transaction: position, heading and lagged
//   velocities as they stood delay_ticks ticks earlier (zero before enough history).
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle;
//   index 0 sample_time, 1 lag_gain, 2 delay_ticks, other indexes are ignored.
// Sequence:
//   m_valid rises after acceptance once ten products have gone through one
//   bit-serial multiplier, each started from an issue state and collected in a wait
//   state, then a history write, a history read and the output load. The CORDIC runs
//   alongside the lag products. One tick is processed at a time; s_ready is high
//   only while the sequencer is idle, so no new tick is taken until it returns there.
// Reset:
//   Synchronous active-low aresetn restores the default registers, zeroes the
//   kinematic state and empties the history (a fill count masks unwritten entries).
// Stall:
//   A finished result waits in the output register; the next tick is accepted
//   meanwhile, and its result is held back until m_ready frees the register.
module planar_robot_kinematic_sim #(
    parameter int DELAY_DEPTH  = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_cmd_vel_x,
    input  logic signed [23:0] s_cmd_vel_y,
    input  logic signed [23:0] s_cmd_turn_rate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic [31:0]        m_heading,
    output logic signed [23:0] m_vel_x,
    output logic signed [23:0] m_vel_y,
    output logic signed [23:0] m_turn_rate
);
    import prks_pkg::*;

    localparam int PTR_W  = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int FILL_W = $clog2(DELAY_DEPTH + 1);
    localparam int DMAX   = DELAY_DEPTH - 1;

    prks_state_t state_reg, state_next;

    logic [15:0] ts_reg, ts_next;
    logic [16:0] gain_reg, gain_next;
    logic [5:0]  dly_reg, dly_next;

    logic signed [23:0] cmd_x_reg, cmd_y_reg, cmd_t_reg;
    logic signed [23:0] lag_x_reg, lag_x_next, lag_y_reg, lag_y_next, lag_t_reg, lag_t_next;
    logic signed [31:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [31:0]        head_reg, head_next;
    logic signed [PROD_W-1:0] tmp_reg, tmp_next, rx_reg, rx_next, ry_reg, ry_next;
    logic [3:0]         op_reg, op_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               hit_reg, hit_next;
    logic               m_valid_reg, m_valid_next;
    prks_hist_t         out_reg, out_next;

    prks_mul_req_t            mreq;
    logic                     mul_start;
    logic                     mul_done;
    logic signed [PROD_W-1:0] mprod;
    logic                     crd_start, crd_done;
    logic signed [CRD_W-1:0]  c_w, s_w;

    logic               accept, out_load, mem_wr, mem_rd;
    logic [16:0]        g;
    logic signed [24:0] diff;
    logic signed [23:0] lag_cur, lag_cmd, lag_new;
    logic signed [CRD_W-1:0]  ca, sa, nsa;
    logic signed [CRD_W-1:0]  step_d, cur_sel, sum;
    logic signed [31:0] sat_sum;
    logic [PTR_W-1:0]   dlim, rd_addr;
    prks_hist_t         wr_data, rd_data;

    // configuration
    always_comb begin
        ts_next   = ts_reg;
        gain_next = gain_reg;
        dly_next  = dly_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SAMPLE_TIME: ts_next   = cfg_data[15:0];
                REG_LAG_GAIN:    gain_next = cfg_data;
                REG_DELAY_TICKS: dly_next  = cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_ISSUE;
            ST_ISSUE: if (op_reg < OP_RX_A || crd_done) state_next = ST_WAIT;
            ST_WAIT:  if (mul_done) state_next = (op_reg == OP_HEAD) ? ST_WRITE : ST_ISSUE;
            ST_WRITE: state_next = ST_READ;
            ST_READ:  state_next = ST_OUT;
            ST_OUT:   if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = 1'b0;
        crd_start = 1'b0;
        mul_start = 1'b0;
        mem_wr    = 1'b0;
        mem_rd    = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  begin
                s_ready   = 1'b1;
                crd_start = s_valid;
            end
            ST_ISSUE: mul_start = (op_reg < OP_RX_A) || crd_done;
            ST_WAIT:  ;
            ST_WRITE: mem_wr = 1'b1;
            ST_READ:  mem_rd = 1'b1;
            ST_OUT:   out_load = !m_valid_reg || m_ready;
            default:  ;
        endcase
    end

    assign accept = s_valid && s_ready;

    // operand selection
    always_comb begin
        g  = (gain_reg > 17'd65536) ? 17'd65536 : gain_reg;
        ca = c_w;
        sa = s_w;
        nsa = -s_w;
        case (op_reg)
            OP_LAG_Y: begin lag_cur = lag_y_reg; lag_cmd = cmd_y_reg; end
            OP_LAG_T: begin lag_cur = lag_t_reg; lag_cmd = cmd_t_reg; end
            default:  begin lag_cur = lag_x_reg; lag_cmd = cmd_x_reg; end
        endcase
        diff = {lag_cmd[23], lag_cmd} - {lag_cur[23], lag_cur};
        mreq.start    = mul_start;
        mreq.a        = {{(MULA_W-25){diff[24]}}, diff};
        mreq.b        = {{(MULB_W-17){1'b0}}, g};
        mreq.b_signed = 1'b0;
        mreq.acc_init = PROD_W'(32768);
        case (op_reg)
            OP_RX_A: begin
                mreq.a = {{(MULA_W-CRD_W){ca[CRD_W-1]}}, ca};
                mreq.b = lag_x_reg;
                mreq.b_signed = 1'b1;
                mreq.acc_init = '0;
            end
            OP_RX_B: begin
                mreq.a = {{(MULA_W-CRD_W){nsa[CRD_W-1]}}, nsa};
                mreq.b = lag_y_reg;
                mreq.b_signed = 1'b1;
                mreq.acc_init = tmp_reg;
            end
            OP_RY_A: begin
                mreq.a = {{(MULA_W-CRD_W){sa[CRD_W-1]}}, sa};
                mreq.b = lag_x_reg;
                mreq.b_signed = 1'b1;
                mreq.acc_init = '0;
            end
            OP_RY_B: begin
                mreq.a = {{(MULA_W-CRD_W){ca[CRD_W-1]}}, ca};
                mreq.b = lag_y_reg;
                mreq.b_signed = 1'b1;
                mreq.acc_init = tmp_reg;
            end
            OP_DIST_X: begin
                mreq.a = rx_reg[MULA_W+13:14];
                mreq.b = {{(MULB_W-16){1'b0}}, ts_reg};
                mreq.acc_init = PROD_W'(64'h8000_0000);
            end
            OP_DIST_Y: begin
                mreq.a = ry_reg[MULA_W+13:14];
                mreq.b = {{(MULB_W-16){1'b0}}, ts_reg};
                mreq.acc_init = PROD_W'(64'h8000_0000);
            end
            OP_HEAD: begin
                mreq.a = {{(MULA_W-24){lag_t_reg[23]}}, lag_t_reg};
                mreq.b = {{(MULB_W-16){1'b0}}, ts_reg};
                mreq.acc_init = {{(PROD_W-32){1'b0}}, head_reg};
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        lag_new = lag_cur + mprod[39:16];
        step_d  = mprod[PROD_W-1:32];
        cur_sel = (op_reg == OP_DIST_Y) ? {{2{cur_y_reg[31]}}, cur_y_reg}
                                        : {{2{cur_x_reg[31]}}, cur_x_reg};
        sum     = cur_sel + step_d;
        if (sum > CRD_W'(64'sh7FFF_FFFF)) begin
            sat_sum = 32'sh7FFF_FFFF;
        end else if (sum < -CRD_W'(64'sh8000_0000)) begin
            sat_sum = 32'sh8000_0000;
        end else begin
            sat_sum = sum[31:0];
        end
        lag_x_next = lag_x_reg;
        lag_y_next = lag_y_reg;
        lag_t_next = lag_t_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        head_next  = head_reg;
        tmp_next   = tmp_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        op_next    = op_reg;
        if (accept) begin
            op_next = OP_LAG_X;
        end
        if (state_reg == ST_WAIT && mul_done) begin
            op_next = op_reg + 4'd1;
            case (op_reg)
                OP_LAG_X:  lag_x_next = lag_new;
                OP_LAG_Y:  lag_y_next = lag_new;
                OP_LAG_T:  lag_t_next = lag_new;
                OP_RX_A:   tmp_next = mprod;
                OP_RX_B:   rx_next = mprod;
                OP_RY_A:   tmp_next = mprod;
                OP_RY_B:   ry_next = mprod;
                OP_DIST_X: cur_x_next = sat_sum;
                OP_DIST_Y: cur_y_next = sat_sum;
                OP_HEAD:   head_next = mprod[31:0];
                default: ;
            endcase
        end

        dlim = (32'(dly_reg) > DMAX) ? PTR_W'(DMAX) : PTR_W'(dly_reg);
        if (ptr_reg >= dlim) begin
            rd_addr = ptr_reg - dlim;
        end else begin
            rd_addr = PTR_W'({1'b0, ptr_reg} + (PTR_W+1)'(DELAY_DEPTH) - {1'b0, dlim});
        end

        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (mem_wr) begin
            if (fill_reg != FILL_W'(DELAY_DEPTH)) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        if (mem_rd) begin
            ptr_next = (ptr_reg == PTR_W'(DMAX)) ? '0 : ptr_reg + PTR_W'(1);
        end
        hit_next = mem_rd ? (FILL_W'(dlim) < fill_reg) : hit_reg;

        wr_data.pos_x     = cur_x_reg;
        wr_data.pos_y     = cur_y_reg;
        wr_data.heading   = head_reg;
        wr_data.vel_x     = lag_x_reg;
        wr_data.vel_y     = lag_y_reg;
        wr_data.turn_rate = lag_t_reg;

        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            out_next     = hit_reg ? rd_data : '0;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ts_reg      <= 16'd655;
            gain_reg    <= 17'd65536;
            dly_reg     <= '0;
            lag_x_reg   <= '0;
            lag_y_reg   <= '0;
            lag_t_reg   <= '0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            head_reg    <= '0;
            op_reg      <= OP_LAG_X;
            ptr_reg     <= '0;
            fill_reg    <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ts_reg      <= ts_next;
            gain_reg    <= gain_next;
            dly_reg     <= dly_next;
            lag_x_reg   <= lag_x_next;
            lag_y_reg   <= lag_y_next;
            lag_t_reg   <= lag_t_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            head_reg    <= head_next;
            op_reg      <= op_next;
            ptr_reg     <= ptr_next;
            fill_reg    <= fill_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
        if (accept) begin
            cmd_x_reg <= s_cmd_vel_x;
            cmd_y_reg <= s_cmd_vel_y;
            cmd_t_reg <= s_cmd_turn_rate;
        end
        tmp_reg <= tmp_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        out_reg <= out_next;
    end

    prks_smul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .done    (mul_done),
        .prod    (mprod)
    );

    prks_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (crd_start),
        .angle   (head_reg),
        .done    (crd_done),
        .cos_out (c_w),
        .sin_out (s_w)
    );

    prks_hist #(
        .DEPTH (DELAY_DEPTH),
        .AW    (PTR_W)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (ptr_reg),
        .wr_data (wr_data),
        .rd_en   (mem_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid     = m_valid_reg;
    assign m_pos_x     = out_reg.pos_x;
    assign m_pos_y     = out_reg.pos_y;
    assign m_heading   = out_reg.heading;
    assign m_vel_x     = out_reg.vel_x;
    assign m_vel_y     = out_reg.vel_y;
    assign m_turn_rate = out_reg.turn_rate;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("transaction accepted but sequencer stayed idle");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid && state_reg == ST_IDLE)
        else $error("result load did not present a transaction");
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(DELAY_DEPTH))
        else $error("history fill count out of range");
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PTR_W'(DMAX))
        else $error("history pointer out of range");
    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_WAIT)
        else $error("multiplier finished outside the wait state");
`endif

endmodule
